[rtl/pdlr_pkg.sv]
// shared constants, types and the reciprocal table of the pcm downmix resampler
// no dependencies
package pdlr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MONO_W = 24;
    localparam int MIX_SHIFT = MONO_W - SAMPLE_W;
    localparam int CHAN_FIELDS = 8;
    localparam int COUNT_W = 4;
    localparam int STEP_W = 21;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 21;

    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd2;
    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 21'd180634;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd1;

    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W = 31;

    typedef struct packed {
        logic run_end;
        logic stream_end;
    } tag_t;

    // floor(2^30 / n) for the clamped channel count
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = 31'd1073741824;
            4'd2:    r = 31'd536870912;
            4'd3:    r = 31'd357913941;
            4'd4:    r = 31'd268435456;
            4'd5:    r = 31'd214748364;
            4'd6:    r = 31'd178956970;
            4'd7:    r = 31'd153391689;
            default: r = 31'd134217728;
        endcase
        return r;
    endfunction

endpackage

[rtl/pdlr_frame_if.sv]
// frame and result channels of the pcm downmix resampler
// depends on pdlr_pkg
interface pdlr_frame_if;
    import pdlr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] chan0_sample;
    logic signed [SAMPLE_W-1:0] chan1_sample;
    logic signed [SAMPLE_W-1:0] chan2_sample;
    logic signed [SAMPLE_W-1:0] chan3_sample;
    logic signed [SAMPLE_W-1:0] chan4_sample;
    logic signed [SAMPLE_W-1:0] chan5_sample;
    logic signed [SAMPLE_W-1:0] chan6_sample;
    logic signed [SAMPLE_W-1:0] chan7_sample;
    logic                       final_frame;

    modport source (
        output valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
               chan4_sample, chan5_sample, chan6_sample, chan7_sample, final_frame,
        input  ready
    );
    modport sink (
        input  valid, chan0_sample, chan1_sample, chan2_sample, chan3_sample,
               chan4_sample, chan5_sample, chan6_sample, chan7_sample, final_frame,
        output ready
    );
endinterface

interface pdlr_result_if;
    import pdlr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MONO_W-1:0] mono_out;
    logic                     run_end;
    logic                     stream_end;

    modport source (output valid, mono_out, run_end, stream_end, input ready);
    modport sink (input valid, mono_out, run_end, stream_end, output ready);
endinterface

[rtl/pdlr_lane.sv]
// one downmix lane: holds its channel sample, zeroed when the channel is unused
// depends on pdlr_pkg
module pdlr_lane #(
    parameter int LANE_INDEX = 0
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [pdlr_pkg::SAMPLE_W-1:0] sample,
    input  logic [pdlr_pkg::COUNT_W-1:0]         count,
    output logic signed [pdlr_pkg::SAMPLE_W-1:0] value
);
    import pdlr_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= (COUNT_W'(LANE_INDEX) < count) ? sample : '0;
        end
    end

    assign value = value_reg;

endmodule

[rtl/pdlr_mix.sv]
// merge of the lanes: sum, scale to q1.23 and divide by the channel count
// division by reciprocal multiply with one correction step; depends on pdlr_pkg
module pdlr_mix #(
    parameter int MAX_CHANNELS = pdlr_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [pdlr_pkg::SAMPLE_W-1:0] lane_value [MAX_CHANNELS],
    input  logic [pdlr_pkg::COUNT_W-1:0]         count,
    output logic signed [pdlr_pkg::MONO_W-1:0]   mono,
    output logic                                 done
);
    import pdlr_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int X_W = SUM_W + MIX_SHIFT;
    localparam int PROD_W = X_W + RECIP_W;
    localparam int QN_W = X_W + COUNT_W + 1;

    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     sum_valid_reg;
    logic [SUM_W-1:0]         mag_sum;
    logic [X_W-1:0]           x_next;
    logic [X_W-1:0]           x_reg;
    logic                     neg_reg;
    logic                     x_valid_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [X_W-1:0]           x_prod_reg;
    logic                     neg_prod_reg;
    logic                     prod_valid_reg;
    logic [X_W-1:0]           q_est;
    logic [QN_W-1:0]          qn1;
    logic [X_W-1:0]           q;
    logic [MONO_W-1:0]        q_low;
    logic signed [MONO_W-1:0] mono_next;
    logic signed [MONO_W-1:0] mono_reg;
    logic                     done_reg;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            sum_next = sum_next + SUM_W'(lane_value[k]);
        end
    end

    assign mag_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign x_next = {mag_sum, {MIX_SHIFT{1'b0}}} + X_W'(count >> 1);

    assign q_est = prod_reg[RECIP_SHIFT +: X_W];
    assign qn1 = QN_W'(QN_W'(q_est) + QN_W'(1)) * QN_W'(count);
    assign q = (QN_W'(x_prod_reg) >= qn1) ? q_est + X_W'(1) : q_est;
    assign q_low = q[MONO_W-1:0];
    assign mono_next = neg_prod_reg ? MONO_W'(-q_low) : MONO_W'(q_low);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= start;
            x_valid_reg <= sum_valid_reg;
            prod_valid_reg <= x_valid_reg;
            done_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg)
        begin
            x_reg <= x_next;
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (x_valid_reg)
        begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'(recip(count));
            x_prod_reg <= x_reg;
            neg_prod_reg <= neg_reg;
        end
        if (prod_valid_reg)
        begin
            mono_reg <= mono_next;
        end
    end

    assign mono = mono_reg;
    assign done = done_reg;

endmodule

[rtl/pdlr_interp.sv]
// linear interpolation pipeline a + (b - a) * frac with rounding, three stages
// stalls as a whole on the result channel; depends on pdlr_pkg, pdlr_result_if
module pdlr_interp #(
    parameter int FRAC_BITS = pdlr_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               issue_valid,
    input  logic signed [pdlr_pkg::MONO_W-1:0] a,
    input  logic signed [pdlr_pkg::MONO_W-1:0] b,
    input  logic [FRAC_BITS-1:0]               frac,
    input  pdlr_pkg::tag_t                     tag,
    output logic                               issue_ready,
    pdlr_result_if.source                      result
);
    import pdlr_pkg::*;

    localparam int DIFF_W = MONO_W + 1;
    localparam int PROD_W = MONO_W + FRAC_BITS;
    localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    logic                     adv;
    logic signed [DIFF_W-1:0] diff;

    logic                     s1_valid_reg;
    logic signed [MONO_W-1:0] s1_a_reg;
    logic [MONO_W-1:0]        s1_mag_reg;
    logic                     s1_neg_reg;
    logic [FRAC_BITS-1:0]     s1_frac_reg;
    tag_t                     s1_tag_reg;

    logic                     s2_valid_reg;
    logic signed [MONO_W-1:0] s2_a_reg;
    logic [PROD_W-1:0]        s2_prod_reg;
    logic                     s2_neg_reg;
    tag_t                     s2_tag_reg;

    logic [PROD_W:0]          rounded;
    logic [DIFF_W-1:0]        r_ext;
    logic signed [DIFF_W-1:0] sum_ext;

    logic                     out_valid_reg;
    logic signed [MONO_W-1:0] out_mono_reg;
    tag_t                     out_tag_reg;

    assign adv = !out_valid_reg || result.ready;
    assign issue_ready = adv;
    assign diff = DIFF_W'(b) - DIFF_W'(a);

    assign rounded = (PROD_W + 1)'(s2_prod_reg) + HALF;
    assign r_ext = {1'b0, rounded[FRAC_BITS +: MONO_W]};
    assign sum_ext = DIFF_W'(s2_a_reg) + (s2_neg_reg ? -r_ext : r_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg <= a;
            s1_mag_reg <= diff[DIFF_W-1] ? MONO_W'(-diff) : MONO_W'(diff);
            s1_neg_reg <= diff[DIFF_W-1];
            s1_frac_reg <= frac;
            s1_tag_reg <= tag;

            s2_a_reg <= s1_a_reg;
            s2_prod_reg <= PROD_W'(s1_mag_reg) * PROD_W'(s1_frac_reg);
            s2_neg_reg <= s1_neg_reg;
            s2_tag_reg <= s1_tag_reg;

            out_mono_reg <= sum_ext[MONO_W-1:0];
            out_tag_reg <= s2_tag_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.mono_out = out_mono_reg;
    assign result.run_end = out_tag_reg.run_end;
    assign result.stream_end = out_tag_reg.stream_end;

endmodule

[rtl/pcm_downmix_linear_resampler.sv]
// pcm downmix and linear resampler: frame in, zero or more mono samples out
// a new frame is taken only in idle, after every result of the last frame has been issued;
// one issue a cycle while the result channel takes them
// reset: asynchronous, clears the stream state, channel_count 2, phase_step 180634
// depends on pdlr_pkg, pdlr_frame_if, pdlr_lane, pdlr_mix, pdlr_interp
module pcm_downmix_linear_resampler #(
    parameter int MAX_CHANNELS = pdlr_pkg::DEF_MAX_CHANNELS,
    parameter int FRAC_BITS = pdlr_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pdlr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [pdlr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pdlr_frame_if.sink                      frame,
    pdlr_result_if.source                   result
);
    import pdlr_pkg::*;

    localparam int POS_W = FRAC_BITS + 5;
    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] TWO_POS = POS_W'(2) << FRAC_BITS;
    localparam logic [31:0] STEP_MIN = 32'(1) << (FRAC_BITS - 4);
    localparam logic [31:0] STEP_MAX = 32'(1) << (FRAC_BITS + 4);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX = 2'd1;
    localparam logic [1:0] ST_RUN1 = 2'd2;
    localparam logic [1:0] ST_RUN2 = 2'd3;

    logic [COUNT_W-1:0]       channel_count_reg;
    logic [STEP_W-1:0]        phase_step_reg;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic                     final_reg;
    logic                     final_next;
    logic signed [MONO_W-1:0] cur_reg;
    logic signed [MONO_W-1:0] cur_next;
    logic signed [MONO_W-1:0] prev_reg;
    logic signed [MONO_W-1:0] prev_next;
    logic                     have_prev_reg;
    logic                     have_prev_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic                     lane_valid_reg;

    logic                     accept;
    logic [COUNT_W-1:0]       n_used;
    logic [31:0]              step_wide;
    logic [31:0]              step_sel;
    logic [POS_W-1:0]         step;
    logic [POS_W-1:0]         next_pos;
    logic                     pos_done;

    logic signed [SAMPLE_W-1:0] chan_sample [CHAN_FIELDS];
    logic signed [SAMPLE_W-1:0] lane_value [MAX_CHANNELS];
    logic signed [MONO_W-1:0]   mono;
    logic                       mix_done;

    logic                     issue_valid;
    logic                     issue_ready;
    logic signed [MONO_W-1:0] issue_a;
    logic signed [MONO_W-1:0] issue_b;
    logic [FRAC_BITS-1:0]     issue_frac;
    tag_t                     issue_tag;

    assign frame.ready = (state_reg == ST_IDLE);
    assign accept = frame.valid && frame.ready;

    assign chan_sample[0] = frame.chan0_sample;
    assign chan_sample[1] = frame.chan1_sample;
    assign chan_sample[2] = frame.chan2_sample;
    assign chan_sample[3] = frame.chan3_sample;
    assign chan_sample[4] = frame.chan4_sample;
    assign chan_sample[5] = frame.chan5_sample;
    assign chan_sample[6] = frame.chan6_sample;
    assign chan_sample[7] = frame.chan7_sample;

    assign n_used = (channel_count_reg == '0) ? COUNT_W'(1) :
                    (channel_count_reg > COUNT_W'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS) :
                    channel_count_reg;

    assign step_wide = 32'(phase_step_reg);
    assign step_sel = (step_wide < STEP_MIN) ? STEP_MIN :
                      (step_wide > STEP_MAX) ? STEP_MAX : step_wide;
    assign step = step_sel[POS_W-1:0];

    assign next_pos = pos_reg + step;
    assign pos_done = (pos_reg >= ONE_POS);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
            phase_step_reg <= PHASE_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_PHASE_STEP:    phase_step_reg <= cfg_wdata[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_CHANNELS; k++)
        begin : g_lane
            pdlr_lane #(
                .LANE_INDEX(k)
            ) u_lane (
                .clk    (clk),
                .load   (accept),
                .sample (chan_sample[k]),
                .count  (n_used),
                .value  (lane_value[k])
            );
        end
    endgenerate

    pdlr_mix #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (lane_valid_reg),
        .lane_value (lane_value),
        .count      (n_used),
        .mono       (mono),
        .done       (mix_done)
    );

    // issue of one output position per cycle while the interpolator can advance
    always_comb
    begin
        issue_valid = 1'b0;
        issue_a = prev_reg;
        issue_b = prev_reg;
        issue_frac = '0;
        issue_tag = '0;
        if (state_reg == ST_RUN1)
        begin
            issue_valid = !pos_done && issue_ready;
            issue_b = cur_reg;
            issue_frac = pos_reg[FRAC_BITS-1:0];
            issue_tag.run_end = (next_pos >= ONE_POS) && !(final_reg && (next_pos < TWO_POS));
        end
        else if (state_reg == ST_RUN2)
        begin
            issue_valid = !pos_done && issue_ready;
            issue_tag.run_end = (next_pos >= ONE_POS);
        end
        issue_tag.stream_end = issue_tag.run_end && final_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        have_prev_next = have_prev_reg;
        pos_next = pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    final_next = frame.final_frame;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (mix_done)
                begin
                    if (!have_prev_reg)
                    begin
                        prev_next = mono;
                        have_prev_next = 1'b1;
                        state_next = final_reg ? ST_RUN2 : ST_IDLE;
                    end
                    else
                    begin
                        cur_next = mono;
                        state_next = ST_RUN1;
                    end
                end
            end
            ST_RUN1:
            begin
                if (pos_done)
                begin
                    pos_next = pos_reg - ONE_POS;
                    prev_next = cur_reg;
                    state_next = final_reg ? ST_RUN2 : ST_IDLE;
                end
                else if (issue_valid)
                begin
                    pos_next = next_pos;
                end
            end
            ST_RUN2:
            begin
                if (pos_done)
                begin
                    prev_next = '0;
                    have_prev_next = 1'b0;
                    pos_next = '0;
                    state_next = ST_IDLE;
                end
                else if (issue_valid)
                begin
                    pos_next = next_pos;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            cur_reg <= '0;
            prev_reg <= '0;
            have_prev_reg <= 1'b0;
            pos_reg <= '0;
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            cur_reg <= cur_next;
            prev_reg <= prev_next;
            have_prev_reg <= have_prev_next;
            pos_reg <= pos_next;
            lane_valid_reg <= accept;
        end
    end

    pdlr_interp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_interp (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .a           (issue_a),
        .b           (issue_b),
        .frac        (issue_frac),
        .tag         (issue_tag),
        .issue_ready (issue_ready),
        .result      (result)
    );

endmodule
